### src/clook_pkg.sv
// ----------------------------------------------------------------------------
// clook_pkg: shared types and constants of the C-LOOK request queue
// Queue depth, sector width, status codes, the sequencer state and the
// control word that the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package clook_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int SECTOR_BITS = 48;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_ADD      = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_FULL       = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COMPARE,
    PH_APPLY
  } phase_t;

  typedef struct packed {
    logic [SECTOR_BITS-1:0] sector;
    logic                   is_write;
  } entry_t;

  typedef struct packed {
    logic                   compare_en;
    logic                   apply_add;
    logic                   apply_pop;
    logic                   new_above_head;
    logic [SECTOR_BITS-1:0] head;
    entry_t                 new_entry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### src/clook_cell.sv
// ----------------------------------------------------------------------------
// clook_cell: one slot of the ordered request queue
// Compares its stored sector against the head and the new sector, joins the
// insertion ripple, and loads from its left or right neighbor when the row
// shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module clook_cell
  import clook_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       occupied,
  input  wire logic       at_tail,
  input  wire logic       found_in,
  output logic            found_out,
  input  wire entry_t     left_entry,
  input  wire entry_t     right_entry,
  output entry_t          entry
);

  logic match;
  logic below_head;
  logic above_new;
  logic cond;

  always_comb begin
    below_head = entry.sector < ctrl.head;
    above_new  = ctrl.new_entry.sector < entry.sector;
    cond       = ctrl.new_above_head ? (below_head | above_new) : (below_head & above_new);
  end

  assign found_out = found_in | match;

  always_ff @(posedge clk) begin
    if (ctrl.compare_en) begin
      match <= occupied & cond;
    end
    if (ctrl.apply_add) begin
      // The first matching slot (or the tail when none matches) takes the new
      // word; every slot after it moves one place to the right.
      if (!found_in && (match || at_tail)) begin
        entry <= ctrl.new_entry;
      end else if (found_in) begin
        entry <= left_entry;
      end
    end
    if (ctrl.apply_pop) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

### src/clook_disk_request_queue.sv
// ----------------------------------------------------------------------------
// clook_disk_request_queue: C-LOOK disk request scheduler
// A row of compare-and-shift cells holds the pending requests in service
// order; adds are inserted relative to the head, dispatches pop the front.
// ----------------------------------------------------------------------------
// Sequence: start is taken only in the idle phase; busy is high through the
// compare and apply phases, and done, registered from the apply phase, pulses
// for one cycle with the result on the ports. A new word is not taken until
// the last one has finished its apply phase.
// Reset: synchronous rst empties the queue and sets the head to all ones.
// The receiver cannot stall; every result is shown for exactly one cycle.
`default_nettype none

module clook_disk_request_queue
  import clook_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   kind,
  input  wire logic [SECTOR_BITS-1:0] sector,
  input  wire logic                   is_write,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [SECTOR_BITS-1:0]      out_sector,
  output logic                        out_is_write
);

  phase_t                 phase;
  phase_t                 phase_next;
  logic [COUNT_W-1:0]     count;
  logic [SECTOR_BITS-1:0] head;
  logic                   req_kind;
  entry_t                 req_entry;
  logic                   accept;
  logic                   compare_en;
  logic                   in_apply;
  logic                   do_add;
  logic                   do_pop;
  logic                   full;
  logic                   empty;
  status_t                status_next;
  cell_ctrl_t             ctrl;

  entry_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] found_chain;

  assign accept = start && !busy;
  assign full   = count == COUNT_W'(QUEUE_DEPTH);
  assign empty  = count == '0;
  assign do_add = in_apply && (req_kind == KIND_ADD) && !full;
  assign do_pop = in_apply && (req_kind == KIND_DISPATCH) && !empty;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE:    if (accept) phase_next = PH_COMPARE;
      PH_COMPARE: phase_next = PH_APPLY;
      PH_APPLY:   phase_next = PH_IDLE;
      default:    phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    compare_en = 1'b0;
    in_apply   = 1'b0;
    case (phase)
      PH_IDLE:    busy = 1'b0;
      PH_COMPARE: begin
        busy       = 1'b1;
        compare_en = 1'b1;
      end
      PH_APPLY: begin
        busy     = 1'b1;
        in_apply = 1'b1;
      end
      default:    busy = 1'b0;
    endcase
  end

  always_comb begin
    if (req_kind == KIND_ADD) begin
      status_next = full ? ST_FULL : ST_ADDED;
    end else begin
      status_next = empty ? ST_EMPTY : ST_DISPATCHED;
    end
  end

  always_comb begin
    ctrl.compare_en     = compare_en;
    ctrl.apply_add      = do_add;
    ctrl.apply_pop      = do_pop;
    ctrl.new_above_head = req_entry.sector > head;
    ctrl.head           = head;
    ctrl.new_entry      = req_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      count <= '0;
      head  <= '1;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= in_apply;
      if (do_add) begin
        count <= count + COUNT_W'(1);
      end
      if (do_pop) begin
        count <= count - COUNT_W'(1);
        head  <= entries[0].sector;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind           <= kind;
      req_entry.sector   <= sector;
      req_entry.is_write <= is_write;
    end
    if (in_apply) begin
      status       <= status_next;
      out_sector   <= do_pop ? entries[0].sector : '0;
      out_is_write <= do_pop ? entries[0].is_write : 1'b0;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   found_in;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_first
      assign found_in   = 1'b0;
      assign left_entry = entries[i];
    end else begin : g_inner
      assign found_in   = found_chain[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_notlast
      assign right_entry = entries[i+1];
    end

    clook_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (COUNT_W'(i) < count),
      .at_tail     (COUNT_W'(i) == count),
      .found_in    (found_in),
      .found_out   (found_chain[i]),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i])
    );
  end

endmodule

`default_nettype wire
